### rtl/core/veh_pkg.sv
package veh_pkg;

	// histogram geometry
	localparam int HIST_ENTRIES = 4096;
	localparam int HIST_BITS = $clog2(HIST_ENTRIES);
	localparam int COUNT_BITS = 20;
	localparam int TOT_BITS = COUNT_BITS + 1;

	// fixed-point widths of the entropy pass
	localparam int FRAC_BITS = 16;
	localparam int E_BITS = $clog2(TOT_BITS);
	localparam int LOG_W = E_BITS + FRAC_BITS;
	localparam int PROD_W = TOT_BITS + LOG_W;
	localparam int SUM_W = PROD_W + 1;
	localparam int HB_W = LOG_W + 1;
	localparam int ENT_W = 21;
	localparam int LN2_W = 32;
	localparam int NATS_W = HB_W + LN2_W;
	localparam logic [LN2_W-1:0] LN2_Q32 = 32'd2977044472;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last_pixel;
	} pixel_t;

	typedef struct packed {
		logic [ENT_W-1:0] entropy;
		logic             index_overflow;
		logic             pixel_overflow;
	} result_t;

endpackage

### rtl/core/view_entropy_histogram.sv
// Histogram of triangle indices over one frame, then its Shannon entropy in
// nats (unsigned Q5.16). After reset the block zeroes its 4096-bin table,
// one bin a cycle, and takes no pixel until the table is clear. An object
// or background pixel then takes a table read, then a write-back through
// the one write port of the table. On the last pixel of a frame the block
// walks the whole table with one shared log2 unit (16 squaring steps per
// nonzero bin) and a bit-serial divider; the log of the pixel count and the
// background term come first, the divide and the scaling last, and the walk
// also zeroes the table for the next frame. Pixels wait during the walk,
// and a new frame may start while the result beat is still held.
module view_entropy_histogram
	import veh_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    pixel_valid,
	output logic    pixel_ready,
	input  pixel_t  pixel,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_PX_RD, ST_PX_UPD, ST_LG_LOAD, ST_LG_STEP,
		ST_TERM_CHK, ST_TERM_MUL, ST_TERM_ACC, ST_NEXT, ST_BIN_RD,
		ST_BIN_DAT, ST_DIV, ST_NATS_MUL, ST_NATS_RND, ST_FIN
	} state_t;

	localparam logic [COUNT_BITS-1:0] BIN_MAX = '1;
	localparam logic [TOT_BITS-1:0] TOT_MAX = '1;
	localparam logic [HIST_BITS:0] WALK_END = (HIST_BITS+1)'(HIST_ENTRIES);
	localparam int DIV_CNT_W = $clog2(SUM_W + 1);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SUM_W - 1);

	state_t state_q;
	pixel_t px_q;
	logic [COUNT_BITS-1:0] mem [HIST_ENTRIES];
	logic [COUNT_BITS-1:0] rdata_q;
	logic [HIST_BITS:0] walk_q;
	logic [TOT_BITS-1:0] bg_q, tot_q;
	logic iovf_q, covf_q;
	logic [TOT_BITS-1:0] c_q;
	logic lg_for_n_q;
	logic [30:0] lg_m_q;
	logic [E_BITS-1:0] lg_e_q;
	logic [FRAC_BITS-1:0] lg_frac_q;
	logic [3:0] lg_cnt_q;
	logic [LOG_W-1:0] logn_q;
	logic [PROD_W-1:0] prod_q;
	logic [SUM_W-1:0] sum_q;
	logic [TOT_BITS-1:0] rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [NATS_W-1:0] nats_q;
	logic [ENT_W-1:0] ent_q;
	logic res_valid_q;
	result_t res_q;

	// pixel decode
	logic [23:0] idx;
	logic idx_out, is_bg;
	assign idx = {px_q.blue, px_q.green, px_q.red};
	assign idx_out = (idx >= 24'(HIST_ENTRIES));
	assign is_bg = (px_q.alpha != 8'hFF);

	// leading one of the log argument
	function automatic logic [E_BITS-1:0] msb_pos(input logic [TOT_BITS-1:0] x);
		logic [E_BITS-1:0] p;
		p = '0;
		for (int i = 0; i < TOT_BITS; i++) begin
			if (x[i]) p = E_BITS'(i);
		end
		return p;
	endfunction

	logic [E_BITS-1:0] ld_e;
	logic [30:0] ld_m;
	assign ld_e = msb_pos(c_q);
	assign ld_m = 31'(c_q) << (5'd30 - 5'(ld_e));

	// one squaring step of the shared log unit
	logic [61:0] sq_full;
	logic [31:0] sq;
	assign sq_full = 62'(lg_m_q) * 62'(lg_m_q);
	assign sq = sq_full[61:30];

	logic [LOG_W-1:0] lc;
	assign lc = {lg_e_q, lg_frac_q};

	// divider trial subtract
	logic [TOT_BITS:0] trial;
	assign trial = {rem_q, sum_q[SUM_W-1]};

	logic [NATS_W-1:0] nats_rnd;
	assign nats_rnd = nats_q + (NATS_W'(1) << 31);

	// table port: one write address, one registered read
	logic mem_we;
	logic [HIST_BITS-1:0] mem_wa, mem_ra;
	logic [COUNT_BITS-1:0] mem_wd;
	always_comb begin
		mem_we = 1'b0;
		mem_wa = walk_q[HIST_BITS-1:0];
		mem_wd = '0;
		mem_ra = walk_q[HIST_BITS-1:0];
		case (state_q)
			ST_CLR: begin
				mem_we = 1'b1;
			end
			ST_PX_RD: begin
				mem_ra = idx[HIST_BITS-1:0];
			end
			ST_PX_UPD: begin
				mem_wa = idx[HIST_BITS-1:0];
				mem_wd = rdata_q + COUNT_BITS'(1);
				mem_we = !is_bg && !idx_out && rdata_q != BIN_MAX && tot_q != TOT_MAX;
			end
			ST_BIN_DAT: begin
				mem_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rdata_q <= mem[mem_ra];
	end

	assign pixel_ready = (state_q == ST_IDLE);
	assign result_valid = res_valid_q;
	assign result = res_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			walk_q <= '0;
			bg_q <= '0;
			tot_q <= '0;
			iovf_q <= 1'b0;
			covf_q <= 1'b0;
			res_valid_q <= 1'b0;
			lg_for_n_q <= 1'b0;
			lg_cnt_q <= '0;
			div_cnt_q <= '0;
		end else begin
			if (res_valid_q && result_ready) res_valid_q <= 1'b0;
			case (state_q)
				ST_CLR: begin
					walk_q <= walk_q + 1'b1;
					if (walk_q == WALK_END - 1'b1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (pixel_valid) begin
						px_q <= pixel;
						state_q <= ST_PX_RD;
					end
				end
				ST_PX_RD: begin
					state_q <= ST_PX_UPD;
				end
				ST_PX_UPD: begin
					if (is_bg) begin
						if (bg_q == TOT_MAX || tot_q == TOT_MAX) covf_q <= 1'b1;
						else begin
							bg_q <= bg_q + 1'b1;
							tot_q <= tot_q + 1'b1;
						end
					end else if (idx_out) begin
						iovf_q <= 1'b1;
					end else if (rdata_q == BIN_MAX || tot_q == TOT_MAX) begin
						covf_q <= 1'b1;
					end else begin
						tot_q <= tot_q + 1'b1;
					end
					if (!px_q.last_pixel) state_q <= ST_IDLE;
					else begin
						// counts of this pixel land now, so look at them next
						state_q <= ST_TERM_CHK;
						lg_for_n_q <= 1'b1;
						sum_q <= '0;
						ent_q <= '0;
						walk_q <= '0;
					end
				end
				ST_TERM_CHK: begin
					if (lg_for_n_q) begin
						if (tot_q == '0) state_q <= ST_FIN;
						else begin
							c_q <= tot_q;
							state_q <= ST_LG_LOAD;
						end
					end else if (c_q == '0) state_q <= ST_NEXT;
					else state_q <= ST_LG_LOAD;
				end
				ST_LG_LOAD: begin
					lg_e_q <= ld_e;
					lg_m_q <= ld_m;
					lg_frac_q <= '0;
					lg_cnt_q <= '0;
					state_q <= ST_LG_STEP;
				end
				ST_LG_STEP: begin
					lg_cnt_q <= lg_cnt_q + 1'b1;
					if (sq[31]) begin
						lg_m_q <= sq[31:1];
						lg_frac_q <= {lg_frac_q[FRAC_BITS-2:0], 1'b1};
					end else begin
						lg_m_q <= sq[30:0];
						lg_frac_q <= {lg_frac_q[FRAC_BITS-2:0], 1'b0};
					end
					if (lg_cnt_q == 4'd15) state_q <= ST_TERM_MUL;
				end
				ST_TERM_MUL: begin
					if (lg_for_n_q) begin
						logn_q <= lc;
						lg_for_n_q <= 1'b0;
						c_q <= bg_q;
						state_q <= ST_TERM_CHK;
					end else begin
						if (lc >= logn_q) prod_q <= '0;
						else prod_q <= PROD_W'(c_q) * PROD_W'(logn_q - lc);
						state_q <= ST_TERM_ACC;
					end
				end
				ST_TERM_ACC: begin
					sum_q <= sum_q + SUM_W'(prod_q);
					state_q <= ST_NEXT;
				end
				ST_NEXT: begin
					if (walk_q == WALK_END) begin
						// rounding half of N rides in the dividend
						sum_q <= sum_q + SUM_W'(tot_q >> 1);
						rem_q <= '0;
						div_cnt_q <= '0;
						state_q <= ST_DIV;
					end else state_q <= ST_BIN_RD;
				end
				ST_BIN_RD: begin
					state_q <= ST_BIN_DAT;
				end
				ST_BIN_DAT: begin
					c_q <= TOT_BITS'(rdata_q);
					walk_q <= walk_q + 1'b1;
					state_q <= ST_TERM_CHK;
				end
				ST_DIV: begin
					// restoring divide, quotient shifts in behind the dividend
					if (trial >= (TOT_BITS+1)'(tot_q)) begin
						rem_q <= TOT_BITS'(trial - (TOT_BITS+1)'(tot_q));
						sum_q <= {sum_q[SUM_W-2:0], 1'b1};
					end else begin
						rem_q <= trial[TOT_BITS-1:0];
						sum_q <= {sum_q[SUM_W-2:0], 1'b0};
					end
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_LAST) state_q <= ST_NATS_MUL;
				end
				ST_NATS_MUL: begin
					nats_q <= NATS_W'(sum_q[HB_W-1:0]) * NATS_W'(LN2_Q32);
					state_q <= ST_NATS_RND;
				end
				ST_NATS_RND: begin
					if (nats_rnd[NATS_W-1:32] > (NATS_W-32)'({ENT_W{1'b1}}))
						ent_q <= '1;
					else ent_q <= nats_rnd[32 +: ENT_W];
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!res_valid_q) begin
						res_q.entropy <= ent_q;
						res_q.index_overflow <= iovf_q;
						res_q.pixel_overflow <= covf_q;
						res_valid_q <= 1'b1;
						bg_q <= '0;
						tot_q <= '0;
						iovf_q <= 1'b0;
						covf_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### bench/view_entropy_histogram_tb.sv
module view_entropy_histogram_tb;
	import veh_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 20000;
	localparam int HOLDOFF_CYCLES = 60000;
	localparam logic [TOT_BITS-1:0] TOT_FULL = '1;
	localparam logic [COUNT_BITS-1:0] BIN_FULL = '1;
	localparam logic [7:0] ALPHA_OBJECT = 8'hFF;

	typedef struct {
		pixel_t pix;
		bit     drain_first;
	} pending_pixel_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    pixel_valid = 1'b0;
	logic    pixel_ready;
	pixel_t  pixel = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	pending_pixel_t pixel_queue[$];
	result_t        entropy_queue[$];

	// frame state of the predictor
	logic [COUNT_BITS-1:0] hist_bins[HIST_ENTRIES];
	logic [TOT_BITS-1:0]   bg_pixels;
	logic [TOT_BITS-1:0]   counted_pixels;
	bit                    idx_over;
	bit                    cnt_over;

	int  errors = 0;
	int  pixels_taken = 0;
	int  quiet_cycles = 0;
	int  holdoff_left = 0;
	bit  holdoff_done = 0;
	int  pushed = 0;
	bit  last_taken = 0;

	view_entropy_histogram uut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.pixel(pixel),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always #5 clk = ~clk;

	// log2 in Q.16 by repeated squaring of the mantissa
	function automatic logic [63:0] log2_q16(input logic [31:0] x);
		int e;
		logic [63:0] m;
		logic [63:0] frac;
		if (x == 0)
			return 64'd0;
		e = 0;
		while (e < 31 && (x >> (e + 1)) != 0)
			e++;
		if (e > 30)
			e = 30;
		m = 64'(x) << (30 - e);
		frac = 0;
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd1 << 31)) begin
				frac = frac | 64'd1;
				m = m >> 1;
			end
		end
		return (64'(e) << 16) | frac;
	endfunction

	function automatic logic [63:0] bin_term(input logic [31:0] c, input logic [63:0] logn);
		logic [63:0] lc;
		if (c == 0)
			return 64'd0;
		lc = log2_q16(c);
		if (lc >= logn)
			return 64'd0;
		return 64'(c) * (logn - lc);
	endfunction

	function automatic logic [ENT_W-1:0] frame_nats();
		logic [63:0] n;
		logic [63:0] logn;
		logic [63:0] s;
		logic [63:0] hb;
		logic [127:0] nats;
		n = 64'(counted_pixels);
		if (n == 0)
			return '0;
		logn = log2_q16(32'(counted_pixels));
		s = bin_term(32'(bg_pixels), logn);
		for (int i = 0; i < HIST_ENTRIES; i++)
			s += bin_term(32'(hist_bins[i]), logn);
		hb = (s + n / 2) / n;
		nats = (128'(hb) * 128'(LN2_Q32) + (128'd1 << 31)) >> 32;
		if (nats > 128'((1 << ENT_W) - 1))
			nats = 128'((1 << ENT_W) - 1);
		return nats[ENT_W-1:0];
	endfunction

	task automatic clear_frame();
		foreach (hist_bins[i])
			hist_bins[i] = '0;
		bg_pixels = '0;
		counted_pixels = '0;
		idx_over = 0;
		cnt_over = 0;
	endtask

	// count one pixel and queue the entropy on the last one
	task automatic count_pixel(input pixel_t p);
		logic [31:0] idx;
		result_t r;
		if (p.alpha != ALPHA_OBJECT) begin
			if (bg_pixels >= TOT_FULL || counted_pixels >= TOT_FULL) begin
				cnt_over = 1;
			end else begin
				bg_pixels++;
				counted_pixels++;
			end
		end else begin
			idx = 32'(p.red) + (32'(p.green) << 8) + (32'(p.blue) << 16);
			if (idx >= HIST_ENTRIES) begin
				idx_over = 1;
			end else if (hist_bins[idx] >= BIN_FULL || counted_pixels >= TOT_FULL) begin
				cnt_over = 1;
			end else begin
				hist_bins[idx]++;
				counted_pixels++;
			end
		end
		if (p.last_pixel) begin
			r.entropy = frame_nats();
			r.index_overflow = idx_over;
			r.pixel_overflow = cnt_over;
			entropy_queue.insert(entropy_queue.size(), r);
			clear_frame();
		end
	endtask

	task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic [7:0] a, input bit last, input bit drain);
		pending_pixel_t e;
		e.pix.red = r;
		e.pix.green = g;
		e.pix.blue = b;
		e.pix.alpha = a;
		e.pix.last_pixel = last;
		e.drain_first = drain;
		pixel_queue.insert(pixel_queue.size(), e);
		pushed++;
	endtask

	// one frame drawn from a small set of in-table bins plus background and stray indices
	task automatic push_frame(input int len, input int nbins, input int bg_pct,
			input int stray_pct, input bit drain);
		logic [11:0] palette[64];
		logic [11:0] idx;
		int pick;
		foreach (palette[i])
			palette[i] = 12'($urandom);
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < bg_pct) begin
				push_pixel(8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom_range(0, 254)), i == len - 1, drain && i == 0);
			end else if (pick < bg_pct + stray_pct) begin
				if ($urandom_range(0, 1))
					push_pixel(8'($urandom), 8'($urandom), 8'($urandom_range(1, 255)),
						ALPHA_OBJECT, i == len - 1, drain && i == 0);
				else
					push_pixel(8'($urandom), 8'($urandom_range(16, 255)), 8'd0,
						ALPHA_OBJECT, i == len - 1, drain && i == 0);
			end else begin
				idx = palette[$urandom_range(0, nbins - 1)];
				push_pixel(idx[7:0], {4'd0, idx[11:8]}, 8'd0, ALPHA_OBJECT,
					i == len - 1, drain && i == 0);
			end
		end
	endtask

	function automatic int send_idle_pct();
		if (pixels_taken < 430)
			return 36;
		if (pixels_taken < 860)
			return 53;
		return 0;
	endfunction

	function automatic int recv_idle_pct();
		if (pixels_taken < 430)
			return 53;
		if (pixels_taken < 860)
			return 36;
		return 0;
	endfunction

	// pixel driver
	always @(negedge clk) begin
		logic next_valid;
		pixel_t next_pix;
		bit held;
		next_valid = pixel_valid;
		next_pix = pixel;
		held = pixel_valid && !last_taken;
		if (arst_n && !held) begin
			next_valid = 1'b0;
			if (pixel_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
				if (!(pixel_queue[0].drain_first && entropy_queue.size() > 0)) begin
					next_pix = pixel_queue[0].pix;
					next_valid = 1'b1;
					void'(pixel_queue.pop_front());
				end
			end
		end
		pixel_valid <= next_valid;
		pixel <= next_pix;
	end

	// result receiver, with one long hold-off
	always @(negedge clk) begin
		logic next_ready;
		if (!holdoff_done && pixels_taken >= 300) begin
			holdoff_done = 1;
			holdoff_left = HOLDOFF_CYCLES;
		end
		if (holdoff_left > 0) begin
			holdoff_left--;
			next_ready = 1'b0;
		end else begin
			next_ready = arst_n && ($urandom_range(0, 99) >= recv_idle_pct());
		end
		result_ready <= next_ready;
	end

	// monitor: prediction on pixel beats, checking on result beats, watchdog
	always @(posedge clk) begin
		result_t exp_r;
		bit moved;
		moved = 0;
		last_taken = 0;
		if (arst_n) begin
			if (pixel_valid && pixel_ready) begin
				count_pixel(pixel);
				pixels_taken++;
				last_taken = 1;
				moved = 1;
			end
			if (result_valid && result_ready) begin
				moved = 1;
				if (entropy_queue.size() == 0) begin
					$display("%0t: unexpected result beat entropy=%0d", $time, result.entropy);
					errors++;
				end else begin
					exp_r = entropy_queue.pop_front();
					if (result.entropy !== exp_r.entropy) begin
						$display("%0t: entropy expected %0d got %0d", $time,
							exp_r.entropy, result.entropy);
						errors++;
					end
					if (result.index_overflow !== exp_r.index_overflow) begin
						$display("%0t: index_overflow expected %0b got %0b", $time,
							exp_r.index_overflow, result.index_overflow);
						errors++;
					end
					if (result.pixel_overflow !== exp_r.pixel_overflow) begin
						$display("%0t: pixel_overflow expected %0b got %0b", $time,
							exp_r.pixel_overflow, result.pixel_overflow);
						errors++;
					end
				end
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("view_entropy_histogram_tb NOT OK");
				$finish;
			end
		end
	end

	// stimulus and end of run
	initial begin
		clear_frame();
		// directed frames: single pixel, table corners, background, strays
		push_pixel(8'd0, 8'd0, 8'd0, ALPHA_OBJECT, 1, 0);
		push_pixel(8'hFF, 8'h0F, 8'd0, ALPHA_OBJECT, 0, 0);
		push_pixel(8'd0, 8'd0, 8'd0, ALPHA_OBJECT, 1, 0);
		push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFE, 0, 0);
		push_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1, 0);
		// empty frame: only out-of-table pixels
		push_pixel(8'hFF, 8'hFF, 8'hFF, ALPHA_OBJECT, 0, 0);
		push_pixel(8'd0, 8'h10, 8'd0, ALPHA_OBJECT, 1, 0);
		// mixed frame with a stray index
		push_pixel(8'd1, 8'd0, 8'd0, ALPHA_OBJECT, 0, 0);
		push_pixel(8'd1, 8'd0, 8'd0, ALPHA_OBJECT, 0, 0);
		push_pixel(8'd2, 8'd0, 8'd0, ALPHA_OBJECT, 0, 0);
		push_pixel(8'h55, 8'hAA, 8'h01, 8'hFF, 0, 0);
		push_pixel(8'd9, 8'd9, 8'd9, 8'd127, 0, 0);
		push_pixel(8'd3, 8'h0A, 8'd0, ALPHA_OBJECT, 1, 0);
		// sender waits for the directed results before going on
		push_frame(6, 3, 20, 10, 1);
		while (pushed < 1300) begin
			if ($urandom_range(0, 9) == 0)
				push_frame($urandom_range(1, 8), $urandom_range(1, 4), 50, 30, 0);
			else
				push_frame($urandom_range(10, 70), $urandom_range(1, 64),
					$urandom_range(0, 40), $urandom_range(0, 8), pushed > 700 && pushed < 760);
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (!(pixel_queue.size() == 0 && !pixel_valid && entropy_queue.size() == 0))
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && entropy_queue.size() == 0)
			$display("view_entropy_histogram_tb OK");
		else
			$display("view_entropy_histogram_tb NOT OK");
		$finish;
	end

endmodule
